// File: sv/simon128_pkg.sv
// Shared types and constants for the Simon 128-bit block cipher.
`timescale 1ns / 1ps

package simon128_pkg;

	typedef struct packed {
		logic        kind;
		logic [63:0] text_hi;
		logic [63:0] text_lo;
	} text_t;

	typedef struct packed {
		logic [63:0] out_hi;
		logic [63:0] out_lo;
	} result_t;

	// register indexes on the configuration port
	localparam logic [2:0] REG_KEY0   = 3'd0;
	localparam logic [2:0] REG_KEY1   = 3'd1;
	localparam logic [2:0] REG_KEY2   = 3'd2;
	localparam logic [2:0] REG_KEY3   = 3'd3;
	localparam logic [2:0] REG_WORDS  = 3'd4;
	localparam logic [2:0] REG_ROUNDS = 3'd5;

	localparam logic [2:0] KEY_WORDS_RESET = 3'd2;

	localparam logic [7:0] DEF_ROUNDS_M2 = 8'd68;
	localparam logic [7:0] DEF_ROUNDS_M3 = 8'd69;
	localparam logic [7:0] DEF_ROUNDS_M4 = 8'd72;

	localparam logic [63:0] SCHED_CONST = 64'd3;

	// z sequences for m = 2, 3, 4; period 62
	localparam logic [63:0] ZSEQ [3] = '{
		64'h3369F885192C0EF5,
		64'h3C2CE51207A635DB,
		64'h3DC94C3A046D678B
	};
	localparam logic [5:0] ZSEQ_LAST = 6'd61;

endpackage

// File: sv/simon128_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module simon128_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: sv/simon128_block_cipher_top.sv
// Simon 128-bit block cipher: configuration registers, key schedule and round sequencer.
`timescale 1ns / 1ps

// Usage
//   Configure over the APB port: key words 0..3 at byte addresses 0x00..0x18,
//   key word count at 0x20, round count at 0x28 (0 selects 68, 69 or 72).
//   A request on the text channel carries kind (0 encrypt, 1 decrypt) and the
//   two 64-bit halves of a block; the result channel returns one block.
//   After any register write the first request first expands the key
//   schedule into the round-key RAM, one key per cycle. With the schedule
//   in place a request runs from accept to result valid through a RAM read
//   set-up state (ST_LOAD), one Feistel round per cycle in ST_RUN (one
//   round-key read per cycle from the RAM) and an output load (ST_OUT).
//   text_ready is high only while the sequencer is idle, so a new block is
//   accepted only once the last has left it. A finished result sits in the
//   output register until taken; the next request is accepted meanwhile,
//   and its result waits in the sequencer until the output register frees.
//   Reset clears the registers to their defaults and marks the schedule
//   stale; the round-key RAM needs no clearing.
//   With an odd round count the output load swaps a and b, so the halves come out in order.

module simon128_block_cipher_top
	import simon128_pkg::*;
#(
	parameter int MAX_ROUNDS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [5:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        text_valid,
	output logic        text_ready,
	input  text_t       text,
	output logic        result_valid,
	input  logic        result_ready,
	output result_t     result
);

	localparam int AW = $clog2(MAX_ROUNDS);
	localparam int RW = $clog2(MAX_ROUNDS + 1);
	localparam logic [8:0] MAX_R9 = 9'(MAX_ROUNDS);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_LOAD,
		ST_RUN,
		ST_OUT
	} state_t;

	function automatic logic [63:0] rotl64(input logic [63:0] x, input int n);
		rotl64 = (x << n) | (x >> (64 - n));
	endfunction

	function automatic logic [63:0] rotr64(input logic [63:0] x, input int n);
		rotr64 = (x >> n) | (x << (64 - n));
	endfunction

	function automatic logic [63:0] ffun(input logic [63:0] x);
		ffun = (rotl64(x, 1) & rotl64(x, 8)) ^ rotl64(x, 2);
	endfunction

	state_t         state_q;
	logic [63:0]    key_q [4];
	logic [2:0]     key_words_q;
	logic [7:0]     round_count_q;
	logic           sched_ok_q;
	logic [RW-1:0]  idx_q;
	logic [5:0]     zc_q;
	logic [63:0]    win_q [4];
	logic [AW-1:0]  rd_idx_q;
	logic           kind_q;
	logic [63:0]    a_q;
	logic [63:0]    b_q;
	logic           result_valid_q;
	result_t        result_q;

	logic           cfg_wr;
	logic [2:0]     cfg_idx;
	logic [2:0]     m_eff;
	logic [1:0]     m_sel;
	logic [7:0]     base_rounds;
	logic [8:0]     rounds9;
	logic [RW-1:0]  rounds;
	logic [AW-1:0]  rd_start;
	logic           use_cfg_key;
	logic [63:0]    sched_tmp;
	logic [63:0]    sched_old;
	logic [63:0]    new_key;
	logic           ram_we;
	logic           ram_re;
	logic [63:0]    round_key;
	logic           upd_b;
	logic           out_free;

	assign pready  = 1'b1;
	assign cfg_wr  = psel & penable & pwrite & pready;
	assign cfg_idx = paddr[5:3];

	always_comb begin
		unique case (cfg_idx) inside
			REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: prdata = key_q[cfg_idx[1:0]];
			REG_WORDS:  prdata = {61'd0, key_words_q};
			REG_ROUNDS: prdata = {56'd0, round_count_q};
			default:    prdata = 64'd0;
		endcase
	end

	// effective key word count and round count
	always_comb begin
		if (key_words_q < 3'd2) begin
			m_eff = 3'd2;
		end else if (key_words_q > 3'd4) begin
			m_eff = 3'd4;
		end else begin
			m_eff = key_words_q;
		end
		m_sel = 2'(m_eff - 3'd2);
		if (round_count_q != 8'd0) begin
			base_rounds = round_count_q;
		end else if (m_eff == 3'd3) begin
			base_rounds = DEF_ROUNDS_M3;
		end else if (m_eff == 3'd4) begin
			base_rounds = DEF_ROUNDS_M4;
		end else begin
			base_rounds = DEF_ROUNDS_M2;
		end
		rounds9  = ({1'b0, base_rounds} > MAX_R9) ? MAX_R9 : {1'b0, base_rounds};
		rounds   = RW'(rounds9);
		rd_start = text.kind ? AW'(rounds - RW'(1)) : '0;
	end

	// key schedule step from the window of the last four keys
	always_comb begin
		use_cfg_key = ({{(RW > 3 ? RW - 3 : 0){1'b0}}, m_eff} > (RW > 3 ? RW : 3)'(idx_q));
		sched_tmp = rotr64(win_q[0], 3);
		if (m_eff == 3'd4) begin
			sched_tmp = sched_tmp ^ win_q[2];
		end
		if (m_eff == 3'd2) begin
			sched_old = win_q[1];
		end else if (m_eff == 3'd3) begin
			sched_old = win_q[2];
		end else begin
			sched_old = win_q[3];
		end
		if (use_cfg_key) begin
			new_key = key_q[idx_q[1:0]];
		end else begin
			new_key = sched_tmp ^ rotr64(sched_tmp, 1) ^ ~sched_old ^ SCHED_CONST
				^ {63'd0, ZSEQ[m_sel][zc_q]};
		end
	end

	assign ram_we = (state_q == ST_EXPAND);
	assign ram_re = (state_q == ST_LOAD) || (state_q == ST_RUN);

	simon128_ram #(
		.WIDTH(64),
		.DEPTH(MAX_ROUNDS)
	) u_round_keys (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q[AW-1:0]),
		.wdata (new_key),
		.re    (ram_re),
		.raddr (rd_idx_q),
		.rdata (round_key)
	);

	assign text_ready = (state_q == ST_IDLE);
	// encrypt updates b on even rounds, decrypt updates a on even rounds
	assign upd_b      = idx_q[0] ~^ kind_q;
	assign out_free   = !result_valid_q || result_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			key_q          <= '{default: 64'd0};
			key_words_q    <= KEY_WORDS_RESET;
			round_count_q  <= 8'd0;
			sched_ok_q     <= 1'b0;
			idx_q          <= '0;
			zc_q           <= '0;
			rd_idx_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				unique case (cfg_idx) inside
					REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
						key_q[cfg_idx[1:0]] <= pwdata;
						sched_ok_q          <= 1'b0;
					end
					REG_WORDS: begin
						key_words_q <= pwdata[2:0];
						sched_ok_q  <= 1'b0;
					end
					REG_ROUNDS: begin
						round_count_q <= pwdata[7:0];
						sched_ok_q    <= 1'b0;
					end
					default: ;
				endcase
			end
			if (state_q == ST_OUT && out_free) begin
				result_valid_q <= 1'b1;
			end else if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (text_valid) begin
						idx_q    <= '0;
						zc_q     <= '0;
						rd_idx_q <= rd_start;
						state_q  <= sched_ok_q ? ST_LOAD : ST_EXPAND;
					end
				end
				ST_EXPAND: begin
					if (!use_cfg_key) begin
						zc_q <= (zc_q == ZSEQ_LAST) ? 6'd0 : zc_q + 6'd1;
					end
					if (idx_q == rounds - RW'(1)) begin
						sched_ok_q <= 1'b1;
						idx_q      <= '0;
						state_q    <= ST_LOAD;
					end else begin
						idx_q <= idx_q + RW'(1);
					end
				end
				ST_LOAD: begin
					rd_idx_q <= kind_q ? rd_idx_q - AW'(1) : rd_idx_q + AW'(1);
					state_q  <= ST_RUN;
				end
				ST_RUN: begin
					rd_idx_q <= kind_q ? rd_idx_q - AW'(1) : rd_idx_q + AW'(1);
					if (idx_q == rounds - RW'(1)) begin
						state_q <= ST_OUT;
					end else begin
						idx_q <= idx_q + RW'(1);
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers: block halves, key window, output
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && text_valid) begin
			kind_q <= text.kind;
			a_q    <= text.text_hi;
			b_q    <= text.text_lo;
		end
		if (state_q == ST_EXPAND) begin
			win_q[3] <= win_q[2];
			win_q[2] <= win_q[1];
			win_q[1] <= win_q[0];
			win_q[0] <= new_key;
		end
		if (state_q == ST_RUN) begin
			if (upd_b) begin
				b_q <= b_q ^ ffun(a_q) ^ round_key;
			end else begin
				a_q <= a_q ^ ffun(b_q) ^ round_key;
			end
		end
		if (state_q == ST_OUT && out_free) begin
			if (rounds[0]) begin
				result_q.out_hi <= b_q;
				result_q.out_lo <= a_q;
			end else begin
				result_q.out_hi <= a_q;
				result_q.out_lo <= b_q;
			end
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
